[sv/dbw_pkg.sv]
// Shared constants, command codes and the symbol table of the drunken-bishop board.
// No dependencies; every other file of the block imports this package.
package dbw_pkg;

  localparam int VAL_W = 5;

  localparam logic [1:0] CMD_NEW  = 2'd0;
  localparam logic [1:0] CMD_WALK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [7:0]       START_RESET = 8'd76;
  localparam logic [VAL_W-1:0] COUNT_MAX   = 5'd25;
  localparam logic [VAL_W-1:0] START_MARK  = 5'd15;
  localparam logic [VAL_W-1:0] END_MARK    = 5'd16;
  localparam logic [7:0]       SYM_BLANK   = 8'h20;

  // ASCII symbol for each visit count, from empty up to the saturation value.
  function automatic logic [7:0] glyph(input logic [VAL_W-1:0] v);
    logic [7:0] g;
    case (v)
      5'd0:    g = 8'h20;
      5'd1:    g = 8'h2E;
      5'd2:    g = 8'h6F;
      5'd3:    g = 8'h2B;
      5'd4:    g = 8'h3D;
      5'd5:    g = 8'h2A;
      5'd6:    g = 8'h42;
      5'd7:    g = 8'h4F;
      5'd8:    g = 8'h58;
      5'd9:    g = 8'h40;
      5'd10:   g = 8'h25;
      5'd11:   g = 8'h26;
      5'd12:   g = 8'h23;
      5'd13:   g = 8'h2F;
      5'd14:   g = 8'h5E;
      5'd15:   g = 8'h24;
      5'd16:   g = 8'h7E;
      5'd17:   g = 8'h7C;
      5'd18:   g = 8'h4D;
      5'd19:   g = 8'h59;
      5'd20:   g = 8'h57;
      5'd21:   g = 8'h3C;
      5'd22:   g = 8'h3E;
      5'd23:   g = 8'h5A;
      5'd24:   g = 8'h53;
      5'd25:   g = 8'h45;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

[sv/dbw_if.sv]
// Request and result channel interfaces of the drunken-bishop board.
// Depends on dbw_pkg for the value width.
interface dbw_in_if import dbw_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] digest_byte;
  logic [7:0] cell_index;

  modport source (output valid, command, digest_byte, cell_index, input ready);
  modport sink   (input valid, command, digest_byte, cell_index, output ready);
endinterface

interface dbw_out_if import dbw_pkg::*;;
  logic             valid;
  logic             ready;
  logic [7:0]       bishop_cell;
  logic [VAL_W-1:0] cell_value;
  logic [7:0]       cell_symbol;

  modport source (output valid, bishop_cell, cell_value, cell_symbol, input ready);
  modport sink   (input valid, bishop_cell, cell_value, cell_symbol, output ready);
endinterface

[sv/drunken_bishop_walk_board.sv]
// Drunken-bishop board: one result per request; a new request is taken only once the previous
// result has been handed to the output register. A read passes through the read state; a walk
// byte takes a move state for each blocked move and a move state then an increment state for each
// move that reaches a new cell (read then write of its count); a new walk runs the clearing sweep.
// Reset (rst_n low, synchronous) starts the same sweep: no request is taken until the sweep has
// cleared every cell of the count memory; configuration writes are taken throughout the sweep.
module drunken_bishop_walk_board import dbw_pkg::*; #(
  parameter int BOARD_WIDTH  = 17,
  parameter int BOARD_HEIGHT = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  dbw_in_if.sink     in_if,
  dbw_out_if.source  out_if
);

  localparam int CELL_COUNT = BOARD_WIDTH * BOARD_HEIGHT;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int XW = $clog2(BOARD_WIDTH);
  localparam int YW = $clog2(BOARD_HEIGHT);
  // Comparison width that holds both an 8-bit index and the cell count itself.
  localparam int CW = ((AW > 8) ? AW : 8) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_MV   = 3'd2;
  localparam logic [2:0] ST_INC  = 3'd3;
  localparam logic [2:0] ST_RDW  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // Clamp a start cell that lies beyond the board to the last cell.
  function automatic logic [AW-1:0] eff_start(input logic [7:0] s);
    logic [AW-1:0] e;
    if (CW'(s) < CW'(CELL_COUNT)) e = AW'(s);
    else e = AW'(CELL_COUNT - 1);
    return e;
  endfunction

  // Control state.
  logic [2:0]       state_r, state_nxt;
  logic [7:0]       start_r;
  logic             clr_cmd_r, clr_cmd_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [XW-1:0]    pos_x_r, pos_x_nxt;
  logic [YW-1:0]    pos_y_r, pos_y_nxt;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [XW-1:0]    clr_x_r, clr_x_nxt;
  logic [YW-1:0]    clr_y_r, clr_y_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic [7:0]       bits_r, bits_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [7:0]       rd_idx_r, rd_idx_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [7:0]       res_sym_r, res_sym_nxt;
  logic [7:0]       out_cell_r, out_cell_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [7:0]       out_sym_r, out_sym_nxt;

  // Visit count memory: one write port, one registered read port.
  logic [VAL_W-1:0] mem [CELL_COUNT];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] rdata_r;

  // One diagonal move from the current cell, clamped per axis at the edges.
  logic             go_r, go_l, go_d, go_u, moved;
  logic [XW-1:0]    mv_x;
  logic [YW-1:0]    mv_y;
  logic [AW-1:0]    mv_pos;

  // Read request decode.
  logic             rd_in_range;
  logic             req_in_range;
  logic [VAL_W-1:0] rd_val;

  logic             accept;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);

  assign out_if.valid       = out_valid_r;
  assign out_if.bishop_cell = out_cell_r;
  assign out_if.cell_value  = out_val_r;
  assign out_if.cell_symbol = out_sym_r;

  always_comb begin
    go_r = bits_r[0] && (pos_x_r != XW'(BOARD_WIDTH - 1));
    go_l = !bits_r[0] && (pos_x_r != '0);
    go_d = bits_r[1] && (pos_y_r != YW'(BOARD_HEIGHT - 1));
    go_u = !bits_r[1] && (pos_y_r != '0);
    moved = go_r || go_l || go_d || go_u;
    mv_x = go_r ? pos_x_r + XW'(1) : (go_l ? pos_x_r - XW'(1) : pos_x_r);
    mv_y = go_d ? pos_y_r + YW'(1) : (go_u ? pos_y_r - YW'(1) : pos_y_r);
    mv_pos = pos_r;
    if (go_r) mv_pos = mv_pos + AW'(1);
    if (go_l) mv_pos = mv_pos - AW'(1);
    if (go_d) mv_pos = mv_pos + AW'(BOARD_WIDTH);
    if (go_u) mv_pos = mv_pos - AW'(BOARD_WIDTH);
  end

  assign req_in_range = CW'(in_if.cell_index) < CW'(CELL_COUNT);
  assign rd_in_range  = CW'(rd_idx_r) < CW'(CELL_COUNT);

  // Marks for a read: the end cell wins over the start cell.
  always_comb begin
    rd_val = rdata_r;
    if (AW'(rd_idx_r) == eff_start(start_r)) rd_val = START_MARK;
    if (AW'(rd_idx_r) == pos_r) rd_val = END_MARK;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cmd_nxt   = clr_cmd_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    clr_idx_nxt   = clr_idx_r;
    clr_x_nxt     = clr_x_r;
    clr_y_nxt     = clr_y_r;
    tgt_nxt       = tgt_r;
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    res_val_nxt   = res_val_r;
    res_sym_nxt   = res_sym_r;
    out_cell_nxt  = out_cell_r;
    out_val_nxt   = out_val_r;
    out_sym_nxt   = out_sym_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = '0;
    mem_raddr     = mv_pos;

    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        mem_raddr = req_in_range ? AW'(in_if.cell_index) : '0;
        if (accept) begin
          res_val_nxt = '0;
          res_sym_nxt = '0;
          rd_idx_nxt  = in_if.cell_index;
          case (in_if.command)
            CMD_NEW: begin
              tgt_nxt     = eff_start(start_r);
              clr_idx_nxt = '0;
              clr_x_nxt   = '0;
              clr_y_nxt   = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = ST_CLR;
            end
            CMD_WALK: begin
              bits_nxt  = in_if.digest_byte;
              cnt_nxt   = '0;
              state_nxt = ST_MV;
            end
            CMD_READ: begin
              state_nxt = ST_RDW;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLR: begin
        // Zero one cell a cycle; pick up the start coordinates on the way past.
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        if (clr_idx_r == tgt_r) begin
          pos_nxt   = clr_idx_r;
          pos_x_nxt = clr_x_r;
          pos_y_nxt = clr_y_r;
        end
        if (clr_x_r == XW'(BOARD_WIDTH - 1)) begin
          clr_x_nxt = '0;
          clr_y_nxt = clr_y_r + YW'(1);
        end else begin
          clr_x_nxt = clr_x_r + XW'(1);
        end
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(CELL_COUNT - 1)) begin
          state_nxt   = clr_cmd_r ? ST_DONE : ST_IDLE;
          clr_cmd_nxt = 1'b0;
        end
      end
      ST_MV: begin
        // The bit pair is used up whether or not the bishop can move.
        bits_nxt = {2'b00, bits_r[7:2]};
        if (moved) begin
          pos_nxt   = mv_pos;
          pos_x_nxt = mv_x;
          pos_y_nxt = mv_y;
          state_nxt = ST_INC;
        end else if (cnt_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_INC: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = (rdata_r < COUNT_MAX) ? rdata_r + VAL_W'(1) : rdata_r;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + 2'd1;
          state_nxt = ST_MV;
        end
      end
      ST_RDW: begin
        if (rd_in_range) begin
          res_val_nxt = rd_val;
          res_sym_nxt = glyph(rd_val);
        end else begin
          res_val_nxt = '0;
          res_sym_nxt = SYM_BLANK;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = 8'(pos_r);
          out_val_nxt   = res_val_r;
          out_sym_nxt   = res_sym_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= START_RESET;
      tgt_r       <= eff_start(START_RESET);
      clr_idx_r   <= '0;
      clr_x_r     <= '0;
      clr_y_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) start_r <= cfg_wdata;
      tgt_r       <= tgt_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_x_r     <= clr_x_nxt;
      clr_y_r     <= clr_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    bits_r     <= bits_nxt;
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_val_r  <= res_val_nxt;
    res_sym_r  <= res_sym_nxt;
    out_cell_r <= out_cell_nxt;
    out_val_r  <= out_val_nxt;
    out_sym_r  <= out_sym_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

endmodule
